// ===== rtl/otrs_pkg.sv =====
// Package for the one-wire temperature read sequencer.
// Holds the wire byte codes, the job descriptor handed from front to back, and sizes.
// No dependencies.
package otrs_pkg;

	// Byte codes on the wire
	localparam logic [7:0] RESET_PULSE  = 8'hF0;
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;
	localparam logic [7:0] SLOT_ONE     = 8'hFF;
	localparam logic [7:0] SLOT_ZERO    = 8'h00;

	// Event kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_XFER = 1'b1;

	// Most result items one event can cause, and counter width
	localparam int MAX_ITEMS = 32;
	localparam int CNT_W     = $clog2(MAX_ITEMS);

	// Default depth of the job queue
	localparam int QUEUE_DEPTH_DEF = 4;

	// What the back end has to send for one event
	typedef enum logic [2:0] {
		JOB_NONE,     // one no-send item
		JOB_RESET,    // reset pulse, slow rate
		JOB_SLOT,     // one polling slot
		JOB_CONVERT,  // Skip ROM + Convert T, 16 slots
		JOB_READ      // Skip ROM + Read Scratchpad + 16 read slots, 32 slots
	} job_code_t;

	typedef struct packed {
		job_code_t   code;
		logic        presence;
		logic [15:0] temperature;
		logic        updated;
	} job_t;

endpackage

// ===== rtl/otrs_front.sv =====
// Front end of the one-wire sequencer: accepts events, tracks phase and sensor state,
// and classifies each event into a job. Depends on otrs_pkg.
module otrs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [7:0]          rx_byte,
	input  logic [15:0]         slot_bits,
	output logic                push_valid,
	input  logic                push_ready,
	output otrs_pkg::job_t      push_job
);
	import otrs_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_INIT_CONVERT,
		PH_CONVERT,
		PH_WAIT_CONVERT,
		PH_INIT_READ,
		PH_READ
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        present_q, present_d;
	logic [15:0] temp_q, temp_d;
	logic        updated_d;
	job_code_t   code_d;
	logic        accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_comb begin
		phase_d   = phase_q;
		present_d = present_q;
		temp_d    = temp_q;
		updated_d = 1'b0;
		code_d    = JOB_NONE;
		if (kind == KIND_TICK) begin
			case (phase_q)
				PH_INIT_CONVERT, PH_CONVERT, PH_INIT_READ, PH_READ: begin
					// tick mid-sequence is ignored
				end
				PH_WAIT_CONVERT: begin
					// stuck conversion: abort
					phase_d   = PH_IDLE;
					present_d = 1'b0;
				end
				default: begin
					phase_d = PH_INIT_CONVERT;
					code_d  = JOB_RESET;
				end
			endcase
		end else begin
			case (phase_q)
				PH_INIT_CONVERT: begin
					present_d = (rx_byte != RESET_PULSE);
					code_d    = JOB_CONVERT;
					phase_d   = PH_CONVERT;
				end
				PH_INIT_READ: begin
					present_d = (rx_byte != RESET_PULSE);
					code_d    = JOB_READ;
					phase_d   = PH_READ;
				end
				PH_CONVERT: begin
					code_d  = JOB_SLOT;
					phase_d = PH_WAIT_CONVERT;
				end
				PH_WAIT_CONVERT: begin
					if (rx_byte[0]) begin
						code_d  = JOB_RESET;
						phase_d = PH_INIT_READ;
					end
				end
				PH_READ: begin
					temp_d    = slot_bits;
					updated_d = 1'b1;
					phase_d   = PH_IDLE;
				end
				default: begin
					// transfer in idle: discarded
				end
			endcase
		end
	end

	assign push_job = '{code: code_d, presence: present_d, temperature: temp_d,
		updated: updated_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			present_q <= 1'b0;
			temp_q    <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			present_q <= present_d;
			temp_q    <= temp_d;
		end
	end

endmodule

// ===== rtl/otrs_fifo.sv =====
// Short job queue between front and back of the one-wire sequencer.
// Register array with wrap-around pointers. Depends on otrs_pkg.
module otrs_fifo #(
	parameter int DEPTH = otrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  otrs_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output otrs_pkg::job_t pop_job
);
	import otrs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

	job_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/otrs_back.sv =====
// Back end of the one-wire sequencer: expands one job into its slot bytes, one result
// item per cycle while out_ready allows, via an output register. Depends on otrs_pkg.
module otrs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  otrs_pkg::job_t     job,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               has_tx,
	output logic [7:0]         tx_byte,
	output logic               fast_rate,
	output logic               last,
	output logic               presence,
	output logic signed [15:0] temperature,
	output logic               temp_updated
);
	import otrs_pkg::*;

	function automatic logic [CNT_W-1:0] last_index(input job_code_t code);
		case (code)
			JOB_CONVERT: last_index = CNT_W'(15);
			JOB_READ:    last_index = CNT_W'(MAX_ITEMS - 1);
			default:     last_index = '0;
		endcase
	endfunction

	// Slot byte number idx of a job: commands go LSB first
	function automatic logic [7:0] slot_byte(input job_code_t code,
		input logic [CNT_W-1:0] idx);
		logic [7:0] cmd;
		cmd = SLOT_ONE;
		case (code)
			JOB_CONVERT: cmd = idx[3] ? CMD_CONVERT : CMD_SKIP_ROM;
			JOB_READ: begin
				case (idx[4:3])
					2'd0:    cmd = CMD_SKIP_ROM;
					2'd1:    cmd = CMD_READ_PAD;
					default: cmd = SLOT_ONE;
				endcase
			end
			default: cmd = SLOT_ONE;
		endcase
		case (code)
			JOB_NONE:  slot_byte = SLOT_ZERO;
			JOB_RESET: slot_byte = RESET_PULSE;
			JOB_SLOT:  slot_byte = SLOT_ONE;
			default:   slot_byte = cmd[idx[2:0]] ? SLOT_ONE : SLOT_ZERO;
		endcase
	endfunction

	logic             active_q;
	job_t             job_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free, emit, is_last, pop;

	assign out_free  = !out_valid_q || out_ready;
	assign emit      = active_q && out_free;
	assign is_last   = (cnt_q == last_index(job_q.code));
	assign pop       = job_valid && (!active_q || (emit && is_last));
	assign job_ready = pop;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (emit && is_last) begin
				active_q <= 1'b0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// job and output payload, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (emit) begin
			has_tx       <= (job_q.code != JOB_NONE);
			tx_byte      <= slot_byte(job_q.code, cnt_q);
			fast_rate    <= (job_q.code != JOB_NONE) && (job_q.code != JOB_RESET);
			last         <= is_last;
			presence     <= job_q.presence;
			temperature  <= $signed(job_q.temperature);
			temp_updated <= job_q.updated;
		end
	end

endmodule

// ===== rtl/onewire_temp_read_sequencer_top.sv =====
// Top level of the one-wire temperature read sequencer over a UART.
// Instantiates otrs_front, otrs_fifo and otrs_back; depends on otrs_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_ready | kind, rx_byte, slot_bits
//  out     | out_valid/out_ready | has_tx, tx_byte, fast_rate, last, presence,
//          |                     | temperature, temp_updated
//
// An input item is taken whenever the job queue has room; the front end updates
// phase, presence and temperature at that edge.
// The back end sends one result item per cycle from its output register: 1 item
// for most events, 16 for the convert command pair, 32 for the read sequence.
// Consecutive jobs follow without a gap, so unstalled rate is one result per cycle.
// Reset (arst_n low) puts the phase in idle, clears presence and temperature,
// and empties the queue. No clearing pass.
// A stall on out_ready holds the output register; the front keeps accepting
// until QUEUE_DEPTH jobs are waiting.
module onewire_temp_read_sequencer_top #(
	parameter int QUEUE_DEPTH = otrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [7:0]         rx_byte,
	input  logic [15:0]        slot_bits,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               has_tx,
	output logic [7:0]         tx_byte,
	output logic               fast_rate,
	output logic               last,
	output logic               presence,
	output logic signed [15:0] temperature,
	output logic               temp_updated
);
	import otrs_pkg::*;

	// front -> queue
	logic push_valid, push_ready;
	job_t push_job;
	// queue -> back
	logic pop_valid, pop_ready;
	job_t pop_job;

	otrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.rx_byte    (rx_byte),
		.slot_bits  (slot_bits),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	otrs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	otrs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (pop_valid),
		.job_ready    (pop_ready),
		.job          (pop_job),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.has_tx       (has_tx),
		.tx_byte      (tx_byte),
		.fast_rate    (fast_rate),
		.last         (last),
		.presence     (presence),
		.temperature  (temperature),
		.temp_updated (temp_updated)
	);

endmodule

// ===== rtl/otrs_checker.sv =====
// Port-level checks for the one-wire temperature read sequencer, bound to the top.
// Depends on otrs_pkg and onewire_temp_read_sequencer_top.
module otrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               has_tx,
	input logic [7:0]         tx_byte,
	input logic               fast_rate,
	input logic               last,
	input logic               temp_updated
);
	import otrs_pkg::*;

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// a no-send item is always the only item of its event
	a_nosend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_tx |-> last && !fast_rate && tx_byte == SLOT_ZERO)
		else $error("no-send item not final");

	// slow rate only carries a lone reset pulse
	a_reset_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_tx && !fast_rate |-> tx_byte == RESET_PULSE && last)
		else $error("bad slow-rate item");

	// fast-rate bytes are slot bytes
	a_slot_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fast_rate |-> has_tx && (tx_byte == SLOT_ONE || tx_byte == SLOT_ZERO))
		else $error("bad slot byte");

	// temperature latch event sends nothing
	a_update_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && temp_updated |-> !has_tx)
		else $error("temperature update with transmit");

endmodule

bind onewire_temp_read_sequencer_top otrs_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.has_tx       (has_tx),
	.tx_byte      (tx_byte),
	.fast_rate    (fast_rate),
	.last         (last),
	.temp_updated (temp_updated)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for onewire_temp_read_sequencer_top: event stimulus, wire item checks.
// Depends on otrs_pkg and the sequencer RTL; nothing else.

import otrs_pkg::*;

// Sequencer phases as the bench tracks them
typedef enum logic [2:0] {
	SEQ_IDLE,
	SEQ_INIT_CONVERT,
	SEQ_CONVERT,
	SEQ_WAIT_CONVERT,
	SEQ_INIT_READ,
	SEQ_READ
} seq_phase_t;

// One result item as it appears on the output ports
typedef struct packed {
	logic        has_tx;
	logic [7:0]  tx_byte;
	logic        fast_rate;
	logic        last;
	logic        presence;
	logic [15:0] temperature;
	logic        temp_updated;
} wire_item_t;

// Tracks sequencer state, works out the wire items of each event, checks the output stream
class wire_item_tracker;
	seq_phase_t  seq_phase   = SEQ_IDLE;
	logic        sensor_seen = 1'b0;
	logic [15:0] temp_raw    = '0;
	wire_item_t  items_due[$];
	wire_item_t  burst[$];
	int          mismatches  = 0;

	function void push_byte(logic [7:0] b, logic fast);
		wire_item_t it;
		it = '0;
		it.has_tx = 1'b1;
		it.tx_byte = b;
		it.fast_rate = fast;
		burst.push_back(it);
	endfunction

	// command byte goes out LSB first, one slot byte per bit
	function void push_cmd(logic [7:0] cmd);
		for (int j = 0; j < 8; j++)
			push_byte(cmd[j] ? SLOT_ONE : SLOT_ZERO, 1'b1);
	endfunction

	function void take_event(logic k, logic [7:0] rx, logic [15:0] slots);
		wire_item_t it;
		logic       updated;
		updated = 1'b0;
		burst.delete();
		if (k == KIND_TICK) begin
			if (seq_phase == SEQ_IDLE) begin
				seq_phase = SEQ_INIT_CONVERT;
				push_byte(RESET_PULSE, 1'b0);
			end else if (seq_phase == SEQ_WAIT_CONVERT) begin
				// stuck conversion: abort
				seq_phase = SEQ_IDLE;
				sensor_seen = 1'b0;
			end
		end else begin
			case (seq_phase)
			SEQ_INIT_CONVERT: begin
				sensor_seen = (rx != RESET_PULSE);
				push_cmd(CMD_SKIP_ROM);
				push_cmd(CMD_CONVERT);
				seq_phase = SEQ_CONVERT;
			end
			SEQ_INIT_READ: begin
				sensor_seen = (rx != RESET_PULSE);
				push_cmd(CMD_SKIP_ROM);
				push_cmd(CMD_READ_PAD);
				push_cmd(SLOT_ONE);
				push_cmd(SLOT_ONE);
				seq_phase = SEQ_READ;
			end
			SEQ_CONVERT: begin
				push_byte(SLOT_ONE, 1'b1);
				seq_phase = SEQ_WAIT_CONVERT;
			end
			SEQ_WAIT_CONVERT: begin
				if (rx[0]) begin
					seq_phase = SEQ_INIT_READ;
					push_byte(RESET_PULSE, 1'b0);
				end
			end
			SEQ_READ: begin
				temp_raw = slots;
				updated = 1'b1;
				seq_phase = SEQ_IDLE;
			end
			default: ;
			endcase
		end
		if (burst.size() == 0) begin
			it = '0;
			burst.push_back(it);
		end
		foreach (burst[i]) begin
			it = burst[i];
			it.last = (i == burst.size() - 1);
			it.presence = sensor_seen;
			it.temperature = temp_raw;
			it.temp_updated = updated;
			items_due.push_back(it);
		end
	endfunction

	function void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_item(wire_item_t got);
		wire_item_t want;
		if (items_due.size() == 0) begin
			$display("%0t: unexpected item, expected none, actual %h", $time, got);
			mismatches++;
			return;
		end
		want = items_due.pop_front();
		compare_field("has_tx", want.has_tx, got.has_tx);
		compare_field("tx_byte", want.tx_byte, got.tx_byte);
		compare_field("fast_rate", want.fast_rate, got.fast_rate);
		compare_field("last", want.last, got.last);
		compare_field("presence", want.presence, got.presence);
		compare_field("temperature", want.temperature, got.temperature);
		compare_field("temp_updated", want.temp_updated, got.temp_updated);
	endfunction
endclass

module tb;
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               kind      = KIND_TICK;
	logic [7:0]         rx_byte   = '0;
	logic [15:0]        slot_bits = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               has_tx;
	logic [7:0]         tx_byte;
	logic               fast_rate;
	logic               last;
	logic               presence;
	logic signed [15:0] temperature;
	logic               temp_updated;

	// idle odds in percent, changed per stimulus phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	wire_item_tracker tracker;

	onewire_temp_read_sequencer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.rx_byte      (rx_byte),
		.slot_bits    (slot_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.has_tx       (has_tx),
		.tx_byte      (tx_byte),
		.fast_rate    (fast_rate),
		.last         (last),
		.presence     (presence),
		.temperature  (temperature),
		.temp_updated (temp_updated)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random back-pressure, odds set by the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Output monitor: values read at the edge are the pre-edge ones
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_item(wire_item_t'({has_tx, tx_byte, fast_rate, last, presence,
				temperature, temp_updated}));
	end

	// Offer one event, with an optional random gap first. Valid stays high from one
	// item to the next when there is no gap, so it is never lowered and raised in one step.
	task automatic send_event(input logic k, input logic [7:0] rx, input logic [15:0] slots);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		rx_byte   <= rx;
		slot_bits <= slots;
		do @(posedge clk); while (!in_ready);
		// accepted at this edge
		tracker.take_event(k, rx, slots);
	endtask

	// Mostly the event that moves the sequence on, with random content; some noise.
	// useful is low for an item the sequencer just ignores.
	task automatic random_event(output bit useful);
		logic        k;
		logic [7:0]  rx;
		logic [15:0] slots;
		int          pick;
		seq_phase_t  ph;
		ph    = tracker.seq_phase;
		pick  = $urandom_range(99);
		rx    = 8'($urandom);
		slots = 16'($urandom);
		// sign boundaries of the temperature now and then
		if ($urandom_range(9) == 0)
			slots = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		case (ph)
		SEQ_IDLE: begin
			k = (pick < 85) ? KIND_TICK : KIND_XFER;
		end
		SEQ_WAIT_CONVERT: begin
			// tick here aborts; a polled slot is mostly done
			k = (pick < 15) ? KIND_TICK : KIND_XFER;
			if ($urandom_range(99) < 80)
				rx[0] = 1'b1;
		end
		default: begin
			k = (pick < 10) ? KIND_TICK : KIND_XFER;
			// echo equal to the pulse means no sensor
			if ($urandom_range(3) == 0)
				rx = RESET_PULSE;
		end
		endcase
		useful = !((k == KIND_TICK && ph != SEQ_IDLE && ph != SEQ_WAIT_CONVERT) ||
			(k == KIND_XFER && ph == SEQ_IDLE));
		send_event(k, rx, slots);
	endtask

	initial begin
		int count;
		bit useful;
		tracker = new;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk: no idling on either side
		send_event(KIND_XFER, 8'h55, 16'hAAAA);      // transfer in idle, discarded
		send_event(KIND_TICK, 8'h00, 16'h0000);      // start: reset pulse
		send_event(KIND_TICK, 8'hFF, 16'hFFFF);      // tick in init_convert, ignored
		send_event(KIND_XFER, RESET_PULSE, 16'h0);   // echo unchanged: no sensor
		send_event(KIND_TICK, 8'h00, 16'h0000);      // tick in convert, ignored
		send_event(KIND_XFER, 8'h00, 16'h0000);      // polling slot goes out
		send_event(KIND_XFER, 8'hFE, 16'h0000);      // poll not done
		send_event(KIND_TICK, 8'h00, 16'h0000);      // stuck conversion aborted
		send_event(KIND_TICK, 8'h00, 16'h0000);
		send_event(KIND_XFER, 8'h00, 16'hFFFF);      // sensor present
		send_event(KIND_XFER, 8'h00, 16'h0000);
		send_event(KIND_XFER, 8'h01, 16'h0000);      // done: second reset pulse
		send_event(KIND_TICK, 8'h01, 16'h0000);      // tick in init_read, ignored
		send_event(KIND_XFER, 8'hE0, 16'h0000);      // read sequence, 32 items
		send_event(KIND_TICK, 8'h00, 16'h0000);      // tick in read, ignored
		send_event(KIND_XFER, 8'h00, 16'h8000);      // most negative temperature
		send_event(KIND_TICK, 8'h00, 16'h0000);
		send_event(KIND_XFER, 8'hFF, 16'h0000);
		send_event(KIND_XFER, 8'h00, 16'h0000);
		send_event(KIND_XFER, 8'hFF, 16'h0000);
		send_event(KIND_XFER, RESET_PULSE, 16'h0);   // no sensor on the read reset
		send_event(KIND_XFER, 8'h00, 16'h7FFF);      // most positive temperature
		send_event(KIND_XFER, 8'hFF, 16'hFFFF);      // idle again, discarded
		send_event(KIND_TICK, 8'h00, 16'h0000);

		// Random part in four idling phases
		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
			default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			count = 0;
			while (count < 75) begin
				random_event(useful);
				if (useful)
					count++;
			end
		end
		in_valid <= 1'b0;

		// drain, then watch a little longer for stray items
		while (tracker.items_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("[onewire_temp_read_sequencer_top] OK");
		else
			$display("[onewire_temp_read_sequencer_top] ERROR");
		$finish;
	end

	// Run limit, far above the slowest correct run
	initial begin
		#4000000;
		$display("[onewire_temp_read_sequencer_top] ERROR");
		$finish;
	end
endmodule

// ===== onewire_temp_read_sequencer_top.f =====
rtl/otrs_pkg.sv
rtl/otrs_front.sv
rtl/otrs_fifo.sv
rtl/otrs_back.sv
rtl/onewire_temp_read_sequencer_top.sv
rtl/otrs_checker.sv
bench/tb.sv
